/* hdl/orbit_elements_to_position_macros.svh */
// Assertion macros used by the orbit position RTL
`ifndef ORBIT_ELEMENTS_TO_POSITION_MACROS_SVH
`define ORBIT_ELEMENTS_TO_POSITION_MACROS_SVH

// same-cycle implication
`define OEP_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define OEP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/oep_pkg.sv */
// Shared types, constants and arithmetic helpers for the orbit position pipeline
package oep_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int POS_BITS     = 40;
   localparam int CORDIC_STEPS = 30;
   localparam int D_BITS       = 36;
   localparam int SUM_BITS     = ((POS_BITS > D_BITS) ? POS_BITS : D_BITS) + 1;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN   = 34'sd2147483648;

   typedef enum logic [2:0] {
      CSR_SEMI_MAJOR = 3'd0,
      CSR_ECCENTRIC  = 3'd1,
      CSR_NODE       = 3'd2,
      CSR_PERICENTER = 3'd3,
      CSR_TILT       = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } sincos_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } dir_type;

   // arctangent of 2^-i as a 32-bit turn fraction
   function automatic logic signed [33:0] atan_turn(input int unsigned idx);
      logic signed [33:0] v;
      case (idx)
         0: v = 34'sd536870912;
         1: v = 34'sd316933406;
         2: v = 34'sd167458907;
         3: v = 34'sd85004756;
         4: v = 34'sd42667331;
         5: v = 34'sd21354465;
         6: v = 34'sd10679838;
         7: v = 34'sd5340245;
         8: v = 34'sd2670163;
         9: v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         24: v = 34'sd41;
         25: v = 34'sd20;
         26: v = 34'sd10;
         27: v = 34'sd5;
         28: v = 34'sd3;
         29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q1.30 product, rounded half up
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] p,
                                                  input logic signed [31:0] q);
      logic signed [63:0] prod;
      prod = p * q + 64'sd536870912;
      return prod[61:30];
   endfunction

   function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > Q30_ONE) begin
         r = 32'sd1073741824;
      end else if (v < -Q30_ONE) begin
         r = -32'sd1073741824;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* hdl/orbit_elements_to_position.sv */
// Orbit position from true anomaly: four 32-stage CORDICs feed direction
// products and radius terms over three stages, a 33-stage divider forms the
// radius, one stage scales the direction and an output register places the
// body. One transaction per clock is sustained while the pipe is not stalled;
// the divider forms one quotient bit per stage. A stall only halts the pipe
// when the output register is held and the last stage is full.
module orbit_elements_to_position (
   input  logic         clock,
   input  logic         reset,
   // anomaly_angle[15:0], host_x[55:16], host_y[95:56], host_z[135:96]
   input  logic [135:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // radius[32:0], body_x[72:33], body_y[112:73], body_z[152:113], zero pad
   output logic [159:0] rsp_tdata,
   // saturated[0]
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

`include "orbit_elements_to_position_macros.svh"

   localparam int AB   = oep_pkg::ANGLE_BITS;
   localparam int PB   = oep_pkg::POS_BITS;
   localparam int SB   = oep_pkg::SUM_BITS;
   localparam int DB   = oep_pkg::D_BITS;
   localparam int LAT  = 69;
   localparam int LAST = LAT - 1;
   localparam int FDLY = 33;
   localparam logic signed [PB-1:0] POS_HI = {1'b0, {(PB-1){1'b1}}};
   localparam logic signed [PB-1:0] POS_LO = {1'b1, {(PB-1){1'b0}}};

   // configuration
   logic [31:0]   semi_major_ff;
   logic [15:0]   ecc_ff;
   logic [AB-1:0] node_ff, peri_ff, tilt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_major_ff <= '0;
         ecc_ff        <= '0;
         node_ff       <= '0;
         peri_ff       <= '0;
         tilt_ff       <= '0;
      end else if (csr_we) begin
         case (oep_pkg::csr_reg_type'(csr_addr))
            oep_pkg::CSR_SEMI_MAJOR: semi_major_ff <= csr_wdata;
            oep_pkg::CSR_ECCENTRIC:  ecc_ff        <= csr_wdata[15:0];
            oep_pkg::CSR_NODE:       node_ff       <= csr_wdata[AB-1:0];
            oep_pkg::CSR_PERICENTER: peri_ff       <= csr_wdata[AB-1:0];
            oep_pkg::CSR_TILT:       tilt_ff       <= csr_wdata[AB-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic           ce, accept;
   logic [LAT-1:0] vld_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   assign ce         = !(rsp_valid_ff && !rsp_tready && vld_ff[LAST]);
   assign req_tready = ce;
   assign accept     = req_tvalid && ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // input fields
   logic [AB-1:0]          nu, u_angle;
   logic signed [PB-1:0]   host_in [0:2];

   assign nu         = req_tdata[AB-1:0];
   assign u_angle    = AB'(peri_ff + nu);
   assign host_in[0] = req_tdata[55:16];
   assign host_in[1] = req_tdata[95:56];
   assign host_in[2] = req_tdata[135:96];

   logic signed [PB-1:0] host_ff [0:LAST][0:2];

   always_ff @(posedge clock) begin
      if (ce) begin
         host_ff[0] <= host_in;
         for (int i = 1; i < LAT; i++) begin
            host_ff[i] <= host_ff[i-1];
         end
      end
   end

   // sine/cosine
   oep_pkg::sincos_type sc_nu, sc_u, sc_n, sc_t;

   oep_cordic u_cordic_nu   (.clock(clock), .ce(ce), .angle(nu),      .result(sc_nu));
   oep_cordic u_cordic_u    (.clock(clock), .ce(ce), .angle(u_angle), .result(sc_u));
   oep_cordic u_cordic_node (.clock(clock), .ce(ce), .angle(node_ff), .result(sc_n));
   oep_cordic u_cordic_tilt (.clock(clock), .ce(ce), .angle(tilt_ff), .result(sc_t));

   // stage A: first products
   logic [33:0]        den_a_ff, den_a_in;
   logic [31:0]        e2_a_ff;
   logic signed [31:0] sucT_a_ff, cncu_a_ff, sncu_a_ff, sust_a_ff, cn_a_ff, sn_a_ff;
   logic signed [48:0] ecos;
   logic signed [34:0] den_wide;

   always_comb begin
      ecos     = $signed({1'b0, ecc_ff}) * sc_nu.cos_v + 49'sd8192;
      den_wide = 35'sd4294967296 + ecos[48:14];
      den_a_in = den_wide[33:0];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         den_a_ff  <= den_a_in;
         e2_a_ff   <= 32'(ecc_ff) * 32'(ecc_ff);
         sucT_a_ff <= oep_pkg::mul_q30(sc_u.sin_v, sc_t.cos_v);
         cncu_a_ff <= oep_pkg::mul_q30(sc_n.cos_v, sc_u.cos_v);
         sncu_a_ff <= oep_pkg::mul_q30(sc_n.sin_v, sc_u.cos_v);
         sust_a_ff <= oep_pkg::mul_q30(sc_u.sin_v, sc_t.sin_v);
         cn_a_ff   <= sc_n.cos_v;
         sn_a_ff   <= sc_n.sin_v;
      end
   end

   // stage B: second products, numerator
   logic [63:0]        num_b_ff;
   logic [33:0]        den_b_ff;
   logic signed [31:0] m1_b_ff, m2_b_ff, cncu_b_ff, sncu_b_ff, sust_b_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         num_b_ff  <= {semi_major_ff, 32'h0} - (64'(semi_major_ff) * 64'(e2_a_ff));
         den_b_ff  <= den_a_ff;
         m1_b_ff   <= oep_pkg::mul_q30(sn_a_ff, sucT_a_ff);
         m2_b_ff   <= oep_pkg::mul_q30(cn_a_ff, sucT_a_ff);
         cncu_b_ff <= cncu_a_ff;
         sncu_b_ff <= sncu_a_ff;
         sust_b_ff <= sust_a_ff;
      end
   end

   // stage C: direction sums, rounded dividend
   logic [64:0]      numr_c_ff;
   logic [33:0]      den_c_ff;
   oep_pkg::dir_type dir_c_ff, dir_c_in;

   always_comb begin
      dir_c_in.x = oep_pkg::clamp_q30(34'(cncu_b_ff) - 34'(m1_b_ff));
      dir_c_in.y = oep_pkg::clamp_q30(34'(sncu_b_ff) + 34'(m2_b_ff));
      dir_c_in.z = oep_pkg::clamp_q30(34'(sust_b_ff));
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         numr_c_ff <= {1'b0, num_b_ff} + {32'h0, den_b_ff[33:1]};
         den_c_ff  <= den_b_ff;
         dir_c_ff  <= dir_c_in;
      end
   end

   // radius divider, direction waits alongside
   logic [32:0]      radius_q;
   oep_pkg::dir_type dir_dly_ff [0:FDLY-1];

   oep_divider u_divider (
      .clock    (clock),
      .ce       (ce),
      .dividend (numr_c_ff),
      .divisor  (den_c_ff),
      .quotient (radius_q)
   );

   always_ff @(posedge clock) begin
      if (ce) begin
         dir_dly_ff[0] <= dir_c_ff;
         for (int i = 1; i < FDLY; i++) begin
            dir_dly_ff[i] <= dir_dly_ff[i-1];
         end
      end
   end

   // stage M: scale direction by radius
   logic [32:0]          r_m_ff;
   logic signed [DB-1:0] d_m_ff [0:2];
   logic signed [DB-1:0] d_m_in [0:2];
   logic signed [31:0]   f_sel  [0:2];

   always_comb begin
      f_sel[0] = dir_dly_ff[FDLY-1].x;
      f_sel[1] = dir_dly_ff[FDLY-1].y;
      f_sel[2] = dir_dly_ff[FDLY-1].z;
      for (int i = 0; i < 3; i++) begin
         logic signed [65:0] prod;
         prod      = $signed({1'b0, radius_q}) * f_sel[i] + 66'sd536870912;
         d_m_in[i] = prod[65:30];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         r_m_ff <= radius_q;
         d_m_ff <= d_m_in;
      end
   end

   // output register: place relative to host, saturate
   logic [32:0]          radius_ff;
   logic signed [PB-1:0] body_ff [0:2];
   logic signed [PB-1:0] body_in [0:2];
   logic                 sat_ff, sat_in, load;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         logic signed [SB-1:0] sum;
         sum = SB'(host_ff[LAST][i]) + SB'(d_m_ff[i]);
         if (sum > SB'(POS_HI)) begin
            body_in[i] = POS_HI;
            sat_in     = 1'b1;
         end else if (sum < SB'(POS_LO)) begin
            body_in[i] = POS_LO;
            sat_in     = 1'b1;
         end else begin
            body_in[i] = sum[PB-1:0];
         end
      end
   end

   assign load = ce && vld_ff[LAST];

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         radius_ff <= r_m_ff;
         body_ff   <= body_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = sat_ff;
   assign rsp_tdata  = {7'h0, body_ff[2], body_ff[1], body_ff[0], radius_ff};

   `OEP_ASSERT_IMPL(a_stall_only_full, clock, reset, !ce, rsp_valid_ff && vld_ff[LAST], "pipe stalled without a blocked result")
   `OEP_ASSERT_NEXT(a_last_stage_loads, clock, reset, ce && vld_ff[LAST], rsp_valid_ff, "last stage item did not reach output")
   `OEP_ASSERT_IMPL(a_sat_at_limit, clock, reset, rsp_valid_ff && sat_ff, body_ff[0] == POS_HI || body_ff[0] == POS_LO || body_ff[1] == POS_HI || body_ff[1] == POS_LO || body_ff[2] == POS_HI || body_ff[2] == POS_LO, "saturated flag without a clipped position")

endmodule

/* hdl/oep_cordic.sv */
// Pipelined CORDIC sine/cosine, one rotation step per stage between the input and output registers
module oep_cordic (
   input  logic                             clock,
   input  logic                             ce,
   input  logic [oep_pkg::ANGLE_BITS-1:0]   angle,
   output oep_pkg::sincos_type              result
);

   localparam int STEPS = oep_pkg::CORDIC_STEPS;

   logic signed [33:0] x_ff [0:STEPS];
   logic signed [33:0] y_ff [0:STEPS];
   logic signed [33:0] a_ff [0:STEPS];
   logic               flip_ff [0:STEPS];

   logic [31:0]        turn;
   logic signed [33:0] a_raw;
   logic signed [33:0] a_in;
   logic               flip_in;
   oep_pkg::sincos_type result_ff, result_in;

   // fold into [-1/4, +1/4] turn
   always_comb begin
      turn  = {angle, {(32 - oep_pkg::ANGLE_BITS){1'b0}}};
      a_raw = 34'(signed'(turn));
      if (a_raw > oep_pkg::Q30_ONE) begin
         a_in    = a_raw - oep_pkg::HALF_TURN;
         flip_in = 1'b1;
      end else if (a_raw < -oep_pkg::Q30_ONE) begin
         a_in    = a_raw + oep_pkg::HALF_TURN;
         flip_in = 1'b1;
      end else begin
         a_in    = a_raw;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_ff[0]    <= a_in;
         x_ff[0]    <= oep_pkg::CORDIC_GAIN;
         y_ff[0]    <= '0;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [33:0] ATAN = oep_pkg::atan_turn(i);
      logic signed [33:0] x_in, y_in, a_nx;
      always_comb begin
         if (!a_ff[i][33]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            a_nx = a_ff[i] - ATAN;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            a_nx = a_ff[i] + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            a_ff[i+1]    <= a_nx;
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_comb begin
      result_in.cos_v = oep_pkg::clamp_q30(x_ff[STEPS]);
      result_in.sin_v = oep_pkg::clamp_q30(y_ff[STEPS]);
      if (flip_ff[STEPS]) begin
         result_in.cos_v = -result_in.cos_v;
         result_in.sin_v = -result_in.sin_v;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* hdl/oep_divider.sv */
// Pipelined restoring divider: 65-bit dividend, 34-bit divisor, 33-bit saturated quotient
module oep_divider (
   input  logic        clock,
   input  logic        ce,
   input  logic [64:0] dividend,
   input  logic [33:0] divisor,
   output logic [32:0] quotient
);

   localparam int QB = 33;

   logic [33:0] rem_ff [0:QB-1];
   logic [32:0] quo_ff [0:QB-1];
   logic [32:0] low_ff [0:QB-1];
   logic [33:0] den_ff [0:QB-1];
   logic        ovf_ff [0:QB-1];

   for (genvar k = 0; k < QB; k++) begin : g_bit
      logic [33:0] rem_src, den_src;
      logic [32:0] quo_src, low_src, quo_in;
      logic        ovf_src;
      logic [34:0] trial;
      logic        ge;
      logic [33:0] rem_in;

      if (k == 0) begin : g_first
         // quotient won't fit 33 bits when the top part already reaches the divisor
         assign rem_src = {2'b00, dividend[64:33]};
         assign den_src = divisor;
         assign quo_src = '0;
         assign low_src = dividend[32:0];
         assign ovf_src = ({2'b00, dividend[64:33]} >= divisor);
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign low_src = low_ff[k-1];
         assign ovf_src = ovf_ff[k-1];
      end

      always_comb begin
         trial  = {rem_src, low_src[QB-1-k]};
         ge     = (trial >= {1'b0, den_src});
         rem_in = ge ? 34'(trial - {1'b0, den_src}) : trial[33:0];
         quo_in = quo_src;
         quo_in[QB-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            low_ff[k] <= low_src;
            den_ff[k] <= den_src;
            ovf_ff[k] <= ovf_src;
         end
      end
   end

   assign quotient = ovf_ff[QB-1] ? '1 : quo_ff[QB-1];

endmodule
